/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// SIT_ASSERT is gated off while reset is asserted; SIT_ASSERT_NR also checks in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SIT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`define SIT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/sit_pkg.sv */
// ----------------------------------------------------------------------------
// sit_pkg
// Types, codes and helpers for the sorted insert table.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int GRP   = 8;
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_READ_OK  = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        key;
    logic [63:0] head;
    logic [31:0] tail;
    logic [14:0] size;
  } entry_t;

  typedef struct packed {
    logic             insert_en;
    entry_t           new_entry;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

  // true when stored entry s keeps its place ahead of new entry n
  function automatic logic stays_ahead(entry_t s, entry_t n);
    logic res;
    if (s.key != n.key) begin
      res = s.key;
    end else if (s.head != n.head) begin
      res = (n.head > s.head);
    end else begin
      res = (n.tail > s.tail);
    end
    return res;
  endfunction

endpackage

/* rtl/sit_in_if.sv */
// ----------------------------------------------------------------------------
// sit_in_if
// Request channel of the sorted insert table.
// ----------------------------------------------------------------------------
interface sit_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        class_key;
  logic [63:0] name_head;
  logic [31:0] name_tail;
  logic [14:0] size_kib;
  logic [5:0]  read_index;

  modport source (
    output valid, op, class_key, name_head, name_tail, size_kib, read_index,
    input  ready
  );
  modport sink (
    input  valid, op, class_key, name_head, name_tail, size_kib, read_index,
    output ready
  );
endinterface

/* rtl/sit_out_if.sv */
// ----------------------------------------------------------------------------
// sit_out_if
// Result channel of the sorted insert table.
// ----------------------------------------------------------------------------
interface sit_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  entry_count;
  logic [5:0]  position;
  logic        out_class_key;
  logic [63:0] out_name_head;
  logic [31:0] out_name_tail;
  logic [14:0] out_size_kib;

  modport source (
    output valid, status, entry_count, position, out_class_key, out_name_head,
           out_name_tail, out_size_kib,
    input  ready
  );
  modport sink (
    input  valid, status, entry_count, position, out_class_key, out_name_head,
           out_name_tail, out_size_kib,
    output ready
  );
endinterface

/* rtl/sorted_insert_table.sv */
// A request steps through the sequencer states in order: accept (idle),
// compare-and-shift (exec), read-tree reduce with position encode (fin) and
// result hold (done); a new request is accepted only once the result is taken.
// Inserts complete in one pass of the cell chain whatever the table fill.
// Reset (rst_n low, synchronous) empties the table and idles the sequencer;
// slot contents are not cleared and no request is taken while reset is low.
// ----------------------------------------------------------------------------
// sorted_insert_table
// Sorted table of entries kept in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
module sorted_insert_table (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_ch,
  sit_out_if.source out_ch
);

  localparam int DEPTH = sit_pkg::DEPTH;
  localparam int IDX_W = sit_pkg::IDX_W;
  localparam int CNT_W = sit_pkg::CNT_W;
  localparam int GRP   = sit_pkg::GRP;
  localparam int NGRP  = sit_pkg::NGRP;

  sit_pkg::state_t state_r, state_nxt;
  logic            in_ready;
  logic            out_valid;
  logic            exec;
  logic            fin;

  logic [1:0]       op_r;
  sit_pkg::entry_t  new_r;
  logic [5:0]       ridx_r;
  logic [CNT_W-1:0] count_r;
  logic             full_r;
  logic             full;

  sit_pkg::cell_ctl_t ctl;
  sit_pkg::entry_t    cell_q [DEPTH];
  logic [DEPTH-1:0]   ahead_vec;
  logic [DEPTH-1:0]   ins_oh;
  logic [DEPTH-1:0]   ins_oh_r;
  logic [DEPTH-1:0]   hit;

  sit_pkg::entry_t grp_nxt [NGRP];
  sit_pkg::entry_t grp_r   [NGRP];

  sit_pkg::entry_t  rd_entry;
  logic [IDX_W-1:0] pos_idx;
  logic [15:0]      pos_wide;
  logic [15:0]      cnt_wide;
  logic             rd_ok;

  logic [2:0]       status_r;
  logic [5:0]       position_r;
  sit_pkg::entry_t  out_entry_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sit_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    exec      = 1'b0;
    fin       = 1'b0;
    case (state_r)
      sit_pkg::S_IDLE: begin
        // hold off requests while reset is low
        in_ready = rst_n;
        if (in_ch.valid) state_nxt = sit_pkg::S_EXEC;
      end
      sit_pkg::S_EXEC: begin
        exec      = 1'b1;
        state_nxt = sit_pkg::S_FIN;
      end
      sit_pkg::S_FIN: begin
        fin       = 1'b1;
        state_nxt = sit_pkg::S_DONE;
      end
      sit_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ch.ready) state_nxt = sit_pkg::S_IDLE;
      end
      default: state_nxt = sit_pkg::S_IDLE;
    endcase
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // request capture
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      op_r           <= in_ch.op;
      new_r.key      <= in_ch.class_key;
      new_r.head     <= in_ch.name_head;
      new_r.tail     <= in_ch.name_tail;
      new_r.size     <= in_ch.size_kib;
      ridx_r         <= in_ch.read_index;
    end
  end

  assign full = (count_r == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (exec) begin
      case (op_r)
        sit_pkg::OP_CLEAR:  count_r <= '0;
        sit_pkg::OP_INSERT: if (!full) count_r <= count_r + CNT_W'(1);
        default:            count_r <= count_r;
      endcase
    end
  end

  assign ctl.insert_en = exec && (op_r == sit_pkg::OP_INSERT) && !full;
  assign ctl.new_entry = new_r;
  assign ctl.count     = count_r;

  // cell chain
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic            ahead_in;
    sit_pkg::entry_t prev_q;
    if (k == 0) begin : g_head
      assign ahead_in = 1'b1;
      assign prev_q   = new_r;
    end else begin : g_body
      assign ahead_in = ahead_vec[k-1];
      assign prev_q   = cell_q[k-1];
    end

    sit_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (IDX_W'(k)),
      .ahead_in (ahead_in),
      .prev_q   (prev_q),
      .ahead    (ahead_vec[k]),
      .q        (cell_q[k])
    );

    assign ins_oh[k] = ahead_in && !ahead_vec[k];
    assign hit[k]    = (16'(k) == 16'(ridx_r));
  end

  // read tree, first level: one partial word per group of cells
  always_comb begin
    int k;
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        k = g * GRP + j;
        if (k < DEPTH) begin
          if (hit[k]) grp_nxt[g] = grp_nxt[g] | cell_q[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      grp_r    <= grp_nxt;
      ins_oh_r <= ins_oh;
      full_r   <= full;
    end
  end

  // second level and insert position encode
  always_comb begin
    rd_entry = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_entry = rd_entry | grp_r[g];
    end
  end

  always_comb begin
    pos_idx = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (ins_oh_r[k]) pos_idx = pos_idx | IDX_W'(k);
    end
  end

  assign pos_wide = 16'(pos_idx);
  assign cnt_wide = 16'(count_r);
  assign rd_ok    = (16'(ridx_r) < cnt_wide);

  // result register
  always_ff @(posedge clk) begin
    if (fin) begin
      case (op_r)
        sit_pkg::OP_CLEAR: begin
          status_r    <= sit_pkg::ST_CLEARED;
          position_r  <= '0;
          out_entry_r <= '0;
        end
        sit_pkg::OP_INSERT: begin
          status_r    <= full_r ? sit_pkg::ST_DROPPED : sit_pkg::ST_INSERTED;
          position_r  <= full_r ? 6'd0 : pos_wide[5:0];
          out_entry_r <= '0;
        end
        sit_pkg::OP_READ: begin
          status_r    <= rd_ok ? sit_pkg::ST_READ_OK : sit_pkg::ST_RANGE;
          position_r  <= ridx_r;
          out_entry_r <= rd_ok ? rd_entry : '0;
        end
        default: begin
          // unused op code behaves as a read
          status_r    <= rd_ok ? sit_pkg::ST_READ_OK : sit_pkg::ST_RANGE;
          position_r  <= ridx_r;
          out_entry_r <= rd_ok ? rd_entry : '0;
        end
      endcase
    end
  end

  assign out_ch.status        = status_r;
  assign out_ch.entry_count   = cnt_wide[6:0];
  assign out_ch.position      = position_r;
  assign out_ch.out_class_key = out_entry_r.key;
  assign out_ch.out_name_head = out_entry_r.head;
  assign out_ch.out_name_tail = out_entry_r.tail;
  assign out_ch.out_size_kib  = out_entry_r.size;

endmodule

/* rtl/sit_cell.sv */
// ----------------------------------------------------------------------------
// sit_cell
// One table slot: compares its entry with the new one and, on an insert,
// keeps it, takes the new entry or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module sit_cell (
  input  logic                     clk,
  input  sit_pkg::cell_ctl_t       ctl,
  input  logic [sit_pkg::IDX_W-1:0] idx,
  input  logic                     ahead_in,
  input  sit_pkg::entry_t          prev_q,
  output logic                     ahead,
  output sit_pkg::entry_t          q
);

  sit_pkg::entry_t entry_r;
  sit_pkg::entry_t entry_nxt;
  logic            occupied;

  assign occupied = (sit_pkg::CNT_W'(idx) < ctl.count);
  assign ahead    = occupied && sit_pkg::stays_ahead(entry_r, ctl.new_entry);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert_en && !ahead) begin
      // first slot behind the kept prefix takes the new word, the rest shift down
      entry_nxt = ahead_in ? ctl.new_entry : prev_q;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule

/* rtl/sit_checker.sv */
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks for the sorted insert table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sit_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [6:0] entry_count,
  input logic [5:0] position
);

  `SIT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count) && $stable(position), "result word changed while stalled")
  `SIT_ASSERT(a_status_code, clk, rst_n, out_valid |-> status <= sit_pkg::ST_CLEARED, "status code out of range")
  `SIT_ASSERT(a_read_in_range, clk, rst_n, out_valid && status == sit_pkg::ST_READ_OK |-> 7'(position) < entry_count, "read ok beyond entry count")
  `SIT_ASSERT(a_clear_empty, clk, rst_n, out_valid && status == sit_pkg::ST_CLEARED |-> entry_count == 7'd0, "clear left entries")
  `SIT_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind sorted_insert_table sit_checker u_sit_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .entry_count (out_ch.entry_count),
  .position    (out_ch.position)
);
